FILE: src/rpa_pkg.sv
// shared types, codes and defaults of the reference-counted page allocator
// no dependencies; imported by every module of the block
package rpa_pkg;

  localparam int unsigned PageCountDef  = 32768;
  localparam int unsigned CountWidthDef = 8;
  localparam int unsigned PageShift     = 12;
  localparam int unsigned AddrW         = 64;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned OutCntW       = 8;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned InDataW       = 64;
  localparam int unsigned OutDataW      = 80;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_ADDREF = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_ADDR   = 3'd1,
    STAT_ZERO_COUNT = 3'd2,
    STAT_NO_PAGES   = 3'd3,
    STAT_SATURATED  = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MEMORY_BASE = 1'd0,
    CFG_KERNEL_END  = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_CALC   = 3'd2,
    S_CHECK  = 3'd3,
    S_UPDATE = 3'd4,
    S_WALK   = 3'd5
  } state_e;

  // free stack controls
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctl_t;

  // count memory port controls
  typedef struct packed {
    logic rd;
    logic wr;
  } cnt_ctl_t;

  typedef struct packed {
    status_e            status;
    logic [AddrW-1:0]   granted;
    logic               released;
    logic [OutCntW-1:0] count_after;
  } result_t;

endpackage

FILE: src/rpa_count_store.sv
// reference count memory: one write port, one read port with registered data
// depends on rpa_pkg
module rpa_count_store import rpa_pkg::*; #(
  parameter int unsigned PAGE_COUNT  = PageCountDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                          clk_i,
  input  cnt_ctl_t                      ctl_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_addr_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_addr_i,
  input  logic [COUNT_WIDTH-1:0]        wr_data_i,
  output logic [COUNT_WIDTH-1:0]        rd_data_o
);

  logic [COUNT_WIDTH-1:0] mem_q [PAGE_COUNT];
  logic [COUNT_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/rpa_free_stack.sv
// last-in-first-out stack of free page indices with its depth pointer
// depends on rpa_pkg
module rpa_free_stack import rpa_pkg::*; #(
  parameter int unsigned PAGE_COUNT = PageCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stk_ctl_t                      ctl_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] push_data_i,
  output logic [$clog2(PAGE_COUNT)-1:0] pop_data_o,
  output logic                          empty_o
);

  localparam int unsigned IdxW = $clog2(PAGE_COUNT);
  localparam int unsigned PtrW = IdxW + 1;
  localparam logic [PtrW-1:0] Full = PtrW'(PAGE_COUNT);

  logic [IdxW-1:0] mem_q [PAGE_COUNT];
  logic [IdxW-1:0] pop_data_q;
  logic [PtrW-1:0] depth_q, depth_d;
  logic [PtrW-1:0] top_ptr;
  logic            do_push;

  assign top_ptr = depth_q - PtrW'(1);
  assign do_push = ctl_i.push && (depth_q != Full);   // a push onto a full stack is dropped
  assign empty_o = (depth_q == '0);

  always_comb begin
    depth_d = depth_q;
    priority if (ctl_i.clear) begin
      depth_d = '0;
    end else if (ctl_i.pop) begin
      depth_d = top_ptr;
    end else if (do_push) begin
      depth_d = depth_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[depth_q[IdxW-1:0]] <= push_data_i;
    end
    if (ctl_i.pop) begin
      pop_data_q <= mem_q[top_ptr[IdxW-1:0]];
    end
  end

  assign pop_data_o = pop_data_q;

endmodule

FILE: src/rpa_ctrl.sv
// command sequencer: address check, count read-modify-write, init and clear walks
// depends on rpa_pkg; drives rpa_count_store and rpa_free_stack
module rpa_ctrl import rpa_pkg::*; #(
  parameter int unsigned PAGE_COUNT  = PageCountDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [AddrW-1:0]              memory_base_i,
  input  logic [AddrW-1:0]              kernel_end_i,
  input  logic                          start_i,
  input  cmd_e                          cmd_i,
  input  logic [AddrW-1:0]              page_address_i,
  output logic                          idle_o,
  output stk_ctl_t                      stk_ctl_o,
  output logic [$clog2(PAGE_COUNT)-1:0] stk_push_data_o,
  input  logic [$clog2(PAGE_COUNT)-1:0] stk_pop_data_i,
  input  logic                          stk_empty_i,
  output cnt_ctl_t                      cnt_ctl_o,
  output logic [$clog2(PAGE_COUNT)-1:0] cnt_rd_addr_o,
  output logic [$clog2(PAGE_COUNT)-1:0] cnt_wr_addr_o,
  output logic [COUNT_WIDTH-1:0]        cnt_wr_data_o,
  input  logic [COUNT_WIDTH-1:0]        cnt_rd_data_i,
  output logic                          res_valid_o,
  output result_t                       res_o
);

  localparam int unsigned IdxW  = $clog2(PAGE_COUNT);
  localparam int unsigned WalkW = IdxW + 1;
  localparam int unsigned PgNW  = AddrW - PageShift;
  localparam logic [WalkW-1:0]       PageCountWalk = WalkW'(PAGE_COUNT);
  localparam logic [WalkW-1:0]       LastWalk      = WalkW'(PAGE_COUNT - 1);
  localparam logic [PgNW-1:0]        PageCountPg   = PgNW'(PAGE_COUNT);
  localparam logic [PgNW:0]          PageCountF    = (PgNW + 1)'(PAGE_COUNT);
  localparam logic [COUNT_WIDTH-1:0] CntMax        = {COUNT_WIDTH{1'b1}};

  state_e            state_q, state_d;
  logic [WalkW-1:0]  walk_q, walk_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  cmd_e              cmd_q;
  logic [AddrW-1:0]  pa_q;

  // offset stage registers
  logic [AddrW-1:0]  off_q, kd_q;
  logic              off_neg_q, aligned_q, kle_q;

  logic [AddrW-1:0]  base;
  logic [AddrW:0]    off_full;
  logic [PgNW:0]     first_f;
  logic [WalkW-1:0]  first_idx;
  logic [IdxW-1:0]   chk_idx;
  logic              addr_ok;
  logic [COUNT_WIDTH-1:0]         cnt_dec, cnt_inc;
  logic [COUNT_WIDTH+OutCntW-1:0] cnt_ext_dec, cnt_ext_old, cnt_ext_inc;

  assign base     = {memory_base_i[AddrW-1:PageShift], {PageShift{1'b0}}};
  assign off_full = {1'b0, pa_q} - {1'b0, base};

  // check stage: page index and validity of the offset
  assign chk_idx = off_q[PageShift +: IdxW];
  assign addr_ok = aligned_q && !off_neg_q
                && (off_q[AddrW-1:PageShift] < PageCountPg)
                && (kle_q || (off_q >= kd_q));

  // first managed page, rounded up, clamped to the page count
  assign first_f = {1'b0, kd_q[AddrW-1:PageShift]} + (PgNW + 1)'(|kd_q[PageShift-1:0]);
  always_comb begin
    priority if (kle_q) begin
      first_idx = '0;
    end else if (first_f > PageCountF) begin
      first_idx = PageCountWalk;
    end else begin
      first_idx = first_f[WalkW-1:0];
    end
  end

  assign cnt_dec     = cnt_rd_data_i - COUNT_WIDTH'(1);
  assign cnt_inc     = cnt_rd_data_i + COUNT_WIDTH'(1);
  assign cnt_ext_dec = {{OutCntW{1'b0}}, cnt_dec};
  assign cnt_ext_old = {{OutCntW{1'b0}}, cnt_rd_data_i};
  assign cnt_ext_inc = {{OutCntW{1'b0}}, cnt_inc};

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d         = state_q;
    walk_d          = walk_q;
    idx_d           = idx_q;
    stk_ctl_o       = '0;
    stk_push_data_o = idx_q;
    cnt_ctl_o       = '0;
    cnt_rd_addr_o   = chk_idx;
    cnt_wr_addr_o   = idx_q;
    cnt_wr_data_o   = '0;
    res_valid_o     = 1'b0;
    res_o           = '0;
    unique case (state_q)
      S_CLEAR: begin
        cnt_ctl_o.wr  = 1'b1;
        cnt_wr_addr_o = walk_q[IdxW-1:0];
        if (walk_q == LastWalk) begin
          walk_d  = '0;
          state_d = S_IDLE;
        end else begin
          walk_d = walk_q + WalkW'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        unique case (cmd_q)
          CMD_INIT: begin
            stk_ctl_o.clear = 1'b1;
            if (first_idx == PageCountWalk) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
            end else begin
              walk_d  = first_idx;
              state_d = S_WALK;
            end
          end
          CMD_ALLOC: begin
            if (stk_empty_i) begin
              res_valid_o  = 1'b1;
              res_o.status = STAT_NO_PAGES;
              state_d      = S_IDLE;
            end else begin
              stk_ctl_o.pop = 1'b1;
              state_d       = S_UPDATE;
            end
          end
          CMD_FREE, CMD_ADDREF: begin
            if (!addr_ok) begin
              res_valid_o  = 1'b1;
              res_o.status = STAT_BAD_ADDR;
              state_d      = S_IDLE;
            end else begin
              cnt_ctl_o.rd = 1'b1;
              idx_d        = chk_idx;
              state_d      = S_UPDATE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_UPDATE: begin
        res_valid_o = 1'b1;
        state_d     = S_IDLE;
        unique case (cmd_q)
          CMD_ALLOC: begin
            cnt_ctl_o.wr      = 1'b1;
            cnt_wr_addr_o     = stk_pop_data_i;
            cnt_wr_data_o     = COUNT_WIDTH'(1);
            res_o.granted     = base + {{(AddrW-IdxW-PageShift){1'b0}}, stk_pop_data_i,
                                        {PageShift{1'b0}}};
            res_o.count_after = OutCntW'(1);
          end
          CMD_FREE: begin
            if (cnt_rd_data_i == '0) begin
              res_o.status = STAT_ZERO_COUNT;
            end else begin
              cnt_ctl_o.wr      = 1'b1;
              cnt_wr_data_o     = cnt_dec;
              res_o.count_after = cnt_ext_dec[OutCntW-1:0];
              if (cnt_dec == '0) begin
                res_o.released = 1'b1;
                stk_ctl_o.push = 1'b1;
              end
            end
          end
          CMD_ADDREF: begin
            if (cnt_rd_data_i == CntMax) begin
              res_o.status      = STAT_SATURATED;
              res_o.count_after = cnt_ext_old[OutCntW-1:0];
            end else begin
              cnt_ctl_o.wr      = 1'b1;
              cnt_wr_data_o     = cnt_inc;
              res_o.count_after = cnt_ext_inc[OutCntW-1:0];
            end
          end
          default: res_o.status = STAT_OK;
        endcase
      end
      S_WALK: begin
        // one managed page per cycle: count to zero, index onto the stack
        cnt_ctl_o.wr    = 1'b1;
        cnt_wr_addr_o   = walk_q[IdxW-1:0];
        stk_ctl_o.push  = 1'b1;
        stk_push_data_o = walk_q[IdxW-1:0];
        if (walk_q == LastWalk) begin
          res_valid_o = 1'b1;
          walk_d      = '0;
          state_d     = S_IDLE;
        end else begin
          walk_d = walk_q + WalkW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (start_i) begin
      cmd_q <= cmd_i;
      pa_q  <= page_address_i;
    end
    if (state_q == S_CALC) begin
      off_q     <= off_full[AddrW-1:0];
      off_neg_q <= off_full[AddrW];
      aligned_q <= (pa_q[PageShift-1:0] == '0);
      kd_q      <= kernel_end_i - base;
      kle_q     <= (kernel_end_i <= base);
    end
  end

endmodule

FILE: src/refcounted_page_allocator.sv
// top level of the reference-counted page allocator: config registers,
// output register, sequencer and the two memories
// depends on rpa_pkg, rpa_count_store, rpa_free_stack, rpa_ctrl
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   s_tuser: command, s_tdata: page_address
//  m_*       out        m_tvalid/m_tready   m_tuser: status, m_tdata: result fields
//  cfg_*     in         cfg_we_i            cfg_idx_i selects the register, cfg_wdata_i
//
// one request at a time; a request passes through these states before the next is taken:
//   alloc, free, addref: offset, check + memory read, update + write back
//   bad address or empty stack: offset, check; init: offset, check, then a walk of the managed pages, if any
// the result enters the output register from the update state (from the check state on a bad
// address, an empty stack or an init with nothing managed, else from the last walk step of init)
// after reset a clearing pass zeroes the count memory and no requests are taken until it ends
// a stalled result holds the output register and blocks the next request
module refcounted_page_allocator import rpa_pkg::*; #(
  parameter int unsigned PAGE_COUNT  = PageCountDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,    // [63:0] page_address
  input  logic [CmdW-1:0]     s_tuser,    // [1:0] command
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,    // [63:0] granted_address, [64] page_released,
                                          // [72:65] count_after, [79:73] zero
  output logic [StatusW-1:0]  m_tuser,    // [2:0] status
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [AddrW-1:0]    cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(PAGE_COUNT);
  localparam logic [AddrW-1:0] CfgResetVal = 64'h0000_0000_8000_0000;

  logic [AddrW-1:0] memory_base_q, kernel_end_q;
  logic             m_valid_q;
  result_t          res_q;

  logic             start;
  logic             ctrl_idle;
  stk_ctl_t         stk_ctl;
  logic [IdxW-1:0]  stk_push_data, stk_pop_data;
  logic             stk_empty;
  cnt_ctl_t         cnt_ctl;
  logic [IdxW-1:0]  cnt_rd_addr, cnt_wr_addr;
  logic [COUNT_WIDTH-1:0] cnt_wr_data, cnt_rd_data;
  logic             res_valid;
  result_t          res;

  // configuration registers; the user must write them only while no request is in flight (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_base_q <= CfgResetVal;
      kernel_end_q  <= CfgResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MEMORY_BASE: memory_base_q <= cfg_wdata_i;
        CFG_KERNEL_END:  kernel_end_q  <= cfg_wdata_i;
        default:         memory_base_q <= memory_base_q;
      endcase
    end
  end

  // take a request when the sequencer is idle and the output slot is free
  // or being emptied in this cycle
  assign s_tready = ctrl_idle && (!m_valid_q || m_tready);
  assign start    = s_tvalid && s_tready;

  // output register; only one request is in flight, so it is free when a result lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tuser  = res_q.status;
  assign m_tdata  = {{(OutDataW-AddrW-1-OutCntW){1'b0}}, res_q.count_after,
                     res_q.released, res_q.granted};

  rpa_ctrl #(
    .PAGE_COUNT  (PAGE_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .memory_base_i   (memory_base_q),
    .kernel_end_i    (kernel_end_q),
    .start_i         (start),
    .cmd_i           (cmd_e'(s_tuser)),
    .page_address_i  (s_tdata),
    .idle_o          (ctrl_idle),
    .stk_ctl_o       (stk_ctl),
    .stk_push_data_o (stk_push_data),
    .stk_pop_data_i  (stk_pop_data),
    .stk_empty_i     (stk_empty),
    .cnt_ctl_o       (cnt_ctl),
    .cnt_rd_addr_o   (cnt_rd_addr),
    .cnt_wr_addr_o   (cnt_wr_addr),
    .cnt_wr_data_o   (cnt_wr_data),
    .cnt_rd_data_i   (cnt_rd_data),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  rpa_free_stack #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (stk_ctl),
    .push_data_i (stk_push_data),
    .pop_data_o  (stk_pop_data),
    .empty_o     (stk_empty)
  );

  rpa_count_store #(
    .PAGE_COUNT  (PAGE_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count_store (
    .clk_i     (clk_i),
    .ctl_i     (cnt_ctl),
    .rd_addr_i (cnt_rd_addr),
    .wr_addr_i (cnt_wr_addr),
    .wr_data_i (cnt_wr_data),
    .rd_data_o (cnt_rd_data)
  );

endmodule

FILE: src/rpa_checker.sv
// port-level checks of the page allocator, bound to the top level
// depends on rpa_pkg and refcounted_page_allocator
module rpa_checker import rpa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic [StatusW-1:0]  m_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no request is taken while the output slot is stalled
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready && m_tvalid |-> m_tready)
    else $error("request accepted with a stalled result");

  // a result never comes from a request accepted at the edge before
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result too early");

  // a released page is a successful free down to zero
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[64] |-> m_tuser == STAT_OK && m_tdata[72:65] == '0)
    else $error("release with bad status or count");

  // a rejected address leaves every result field at zero
  a_bad_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser == STAT_BAD_ADDR |-> m_tdata == '0)
    else $error("bad address result carries data");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: test/refcounted_page_allocator_tb.sv
`timescale 1ns / 100ps
// self-checking bench for refcounted_page_allocator: a directed table, then random requests
// depends on rpa_pkg and the block itself; an internal model predicts every result

module refcounted_page_allocator_tb import rpa_pkg::*;;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned PAGE_COUNT  = PageCountDef;
  localparam int unsigned IDX_W       = $clog2(PageCountDef);
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;
  // longest quiet stretch: clearing pass, then a full walk of the free list, with margin
  localparam int unsigned QUIET_LIMIT = 4 * PageCountDef + 20000;
  localparam int unsigned SCENARIOS   = 5;
  localparam int unsigned SCEN_ITEMS  = 27;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic {ROW_REG, ROW_REQ} row_kind_e;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    row_kind_e   kind;
    cfg_idx_e    sel;
    cmd_e        cmd;
    logic [63:0] value;
    logic [9:0]  reps;
    logic        typed;
    result_t     want;
  } step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;    // [63:0] page_address
  logic [CmdW-1:0]     s_tuser;    // [1:0] command
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;    // [63:0] granted_address, [64] page_released,
                                   // [72:65] count_after, [79:73] zero
  logic [StatusW-1:0]  m_tuser;    // [2:0] status
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [AddrW-1:0]    cfg_wdata_i;

  // allocator model state
  logic [IDX_W-1:0] page_stack [PAGE_COUNT];
  logic [7:0]       page_refs  [PAGE_COUNT];
  int unsigned      stack_fill;
  logic [63:0]      cur_base;
  logic [63:0]      cur_kend;
  int unsigned      walk_cycles;   // pages walked by the last init

  result_t     pending_results [$];
  step_t       directed_steps [$];
  int unsigned send_pct, recv_pct;
  int unsigned quiet_cycles;
  int unsigned mismatches, results_checked, requests_sent;
  int unsigned status_tally [8];

  refcounted_page_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // allocator model
  // ---------------------------------------------------------------------------

  // base address with the in-page bits dropped
  function automatic logic [63:0] aligned_base();
    return {cur_base[63:12], 12'd0};
  endfunction

  // first managed page: kernel end rounded up to a page, clamped to the pool
  function automatic int unsigned first_managed();
    logic [63:0] b, d, f;
    b = aligned_base();
    if (cur_kend <= b) return 0;
    d = cur_kend - b;
    f = (d >> 12) + (d[11:0] != 12'd0);
    return (f > PAGE_COUNT) ? PAGE_COUNT : int'(f);
  endfunction

  // aligned, inside the pool and at or above the kernel end
  function automatic bit managed_page(input logic [63:0] pa, output int unsigned idx);
    logic [63:0] b, i;
    b   = aligned_base();
    idx = 0;
    if (pa[11:0] != 12'd0 || pa < b) return 1'b0;
    i = (pa - b) >> 12;
    if (i >= PAGE_COUNT || i < first_managed()) return 1'b0;
    idx = int'(i);
    return 1'b1;
  endfunction

  // a push onto a full list is lost
  function automatic void push_free(input int unsigned idx);
    if (stack_fill < PAGE_COUNT) begin
      page_stack[stack_fill] = idx[IDX_W-1:0];
      stack_fill++;
    end
  endfunction

  // applies one request to the model and returns the result it must produce
  function automatic result_t predict_request(input cmd_e cmd, input logic [63:0] pa);
    result_t     res;
    int unsigned idx, lo;
    res        = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_INIT: begin
        lo         = first_managed();
        stack_fill = 0;
        for (int unsigned i = lo; i < PAGE_COUNT; i++) begin
          page_refs[i] = '0;
          push_free(i);
        end
        walk_cycles = PAGE_COUNT - lo;
      end
      CMD_ALLOC: begin
        if (stack_fill == 0) begin
          res.status = STAT_NO_PAGES;
        end else begin
          stack_fill--;
          idx             = page_stack[stack_fill];
          page_refs[idx]  = 8'd1;
          res.granted     = aligned_base() + (64'(idx) << 12);
          res.count_after = 8'd1;
        end
      end
      default: begin
        if (!managed_page(pa, idx)) begin
          res.status = STAT_BAD_ADDR;
        end else if (cmd == CMD_FREE) begin
          if (page_refs[idx] == 8'd0) begin
            res.status = STAT_ZERO_COUNT;
          end else begin
            page_refs[idx]--;
            res.count_after = page_refs[idx];
            if (page_refs[idx] == 8'd0) begin
              res.released = 1'b1;
              push_free(idx);
            end
          end
        end else begin
          if (page_refs[idx] == COUNT_MAX) begin
            res.status = STAT_SATURATED;
          end else begin
            page_refs[idx]++;
          end
          res.count_after = page_refs[idx];
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  function automatic void plan_reg(input cfg_idx_e sel, input logic [63:0] value);
    step_t s;
    s       = '0;
    s.kind  = ROW_REG;
    s.sel   = sel;
    s.value = value;
    directed_steps.push_back(s);
  endfunction

  // request rows left to the model
  function automatic void plan_req(input cmd_e cmd, input logic [63:0] addr,
                                   input int unsigned reps);
    step_t s;
    s       = '0;
    s.kind  = ROW_REQ;
    s.cmd   = cmd;
    s.value = addr;
    s.reps  = 10'(reps);
    directed_steps.push_back(s);
  endfunction

  // request rows with the result typed in
  function automatic void plan_chk(input cmd_e cmd, input logic [63:0] addr,
                                   input status_e status, input logic [63:0] granted,
                                   input logic released, input logic [7:0] count);
    step_t s;
    s                  = '0;
    s.kind             = ROW_REQ;
    s.cmd              = cmd;
    s.value            = addr;
    s.reps             = 10'd1;
    s.typed            = 1'b1;
    s.want.status      = status;
    s.want.granted     = granted;
    s.want.released    = released;
    s.want.count_after = count;
    directed_steps.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // request side: called and returning at a falling edge, valid left high
  // ---------------------------------------------------------------------------

  task automatic send_req(input cmd_e cmd, input logic [63:0] addr,
                          input bit use_want, input result_t want);
    result_t pred;
    // random idle cycles before the request
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= addr;
    do @(posedge clk_i); while (!s_tready);
    // accepted at this edge: advance the model
    pred = predict_request(cmd, addr);
    pending_results.push_back(use_want ? want : pred);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input cfg_idx_e sel, input logic [63:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    // margin after the last result, longer after a long init
    repeat (8 + walk_cycles) @(negedge clk_i);
    walk_cycles = 0;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_MEMORY_BASE) begin
      cur_base = value;
    end else begin
      cur_kend = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready changes at the falling edge; stall rate set per phase
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_pct);
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      results_checked++;
      status_tally[m_tuser]++;
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: result with nothing expected: status %0d data %h",
                   $realtime, m_tuser, m_tdata);
        end
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status || m_tdata[63:0] !== want.granted
            || m_tdata[64] !== want.released || m_tdata[72:65] !== want.count_after
            || m_tdata[79:73] !== 7'd0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: result %0d expected status %0d granted %h released %0b count %0d",
                     $realtime, results_checked, want.status, want.granted,
                     want.released, want.count_after);
            $display("%0t: result %0d got      status %0d granted %h released %0b count %0d pad %h",
                     $realtime, results_checked, m_tuser, m_tdata[63:0], m_tdata[64],
                     m_tdata[72:65], m_tdata[79:73]);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles in a row with no request and no result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main flow
  // ---------------------------------------------------------------------------

  initial begin
    logic [63:0] base_reg, kend_reg, b_al, pa;
    int unsigned pool, first, idx, r;
    cmd_e        cmd;

    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_INIT;
    m_tready    = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_MEMORY_BASE;
    cfg_wdata_i = '0;
    send_pct    = 0;
    recv_pct    = 0;
    quiet_cycles    = 0;
    mismatches      = 0;
    results_checked = 0;
    requests_sent   = 0;
    walk_cycles     = 0;
    foreach (status_tally[k]) status_tally[k] = 0;

    // model reset state, matching the register defaults
    cur_base   = 64'h8000_0000;
    cur_kend   = 64'h8000_0000;
    stack_fill = 0;
    foreach (page_refs[k]) begin
      page_refs[k]  = '0;
      page_stack[k] = '0;
    end

    // directed table
    // nothing on the list yet, page 0 managed but never counted
    plan_chk(CMD_ALLOC,  64'h0,           STAT_NO_PAGES,   64'd0, 1'b0, 8'd0);
    plan_chk(CMD_FREE,   64'h8000_0000,   STAT_ZERO_COUNT, 64'd0, 1'b0, 8'd0);
    // misaligned, below base, one page past the top
    plan_chk(CMD_ADDREF, 64'h8000_0001,   STAT_BAD_ADDR,   64'd0, 1'b0, 8'd0);
    plan_chk(CMD_FREE,   64'h7FFF_F000,   STAT_BAD_ADDR,   64'd0, 1'b0, 8'd0);
    plan_chk(CMD_ADDREF, 64'h8800_0000,   STAT_BAD_ADDR,   64'd0, 1'b0, 8'd0);
    // kernel end inside a page: rounds up, leaving the top three pages
    plan_reg(CFG_KERNEL_END, 64'h87FF_C001);
    plan_chk(CMD_INIT,   '1,              STAT_OK,         64'd0, 1'b0, 8'd0);
    // last page pushed comes out first
    plan_chk(CMD_ALLOC,  64'h0,           STAT_OK,         64'h87FF_F000, 1'b0, 8'd1);
    // page just under the kernel end
    plan_chk(CMD_FREE,   64'h87FF_C000,   STAT_BAD_ADDR,   64'd0, 1'b0, 8'd0);
    // count up to the top, then one more
    plan_req(CMD_ADDREF, 64'h87FF_F000, 254);
    plan_chk(CMD_ADDREF, 64'h87FF_F000,   STAT_SATURATED,  64'd0, 1'b0, 8'hFF);
    plan_req(CMD_FREE,   64'h87FF_F000, 254);
    plan_chk(CMD_FREE,   64'h87FF_F000,   STAT_OK,         64'd0, 1'b1, 8'd0);
    // drain the list, then one alloc too many
    plan_req(CMD_ALLOC,  64'h0, 3);
    plan_chk(CMD_ALLOC,  64'h0,           STAT_NO_PAGES,   64'd0, 1'b0, 8'd0);
    plan_req(CMD_ADDREF, 64'h87FF_D000, 1);
    // init again over held pages
    plan_chk(CMD_INIT,   64'h0,           STAT_OK,         64'd0, 1'b0, 8'd0);
    // kernel end past the top: nothing managed
    plan_reg(CFG_KERNEL_END, '1);
    plan_chk(CMD_INIT,   64'h0,           STAT_OK,         64'd0, 1'b0, 8'd0);
    plan_chk(CMD_ALLOC,  64'h0,           STAT_NO_PAGES,   64'd0, 1'b0, 8'd0);
    // fill the list to the brim: all pages but page 0, then a duplicate of page 5
    plan_reg(CFG_MEMORY_BASE, 64'h8000_0FFF);
    plan_reg(CFG_KERNEL_END,  64'h8000_0001);
    plan_chk(CMD_INIT,   64'h0,           STAT_OK,         64'd0, 1'b0, 8'd0);
    plan_reg(CFG_KERNEL_END,  64'h0);
    plan_chk(CMD_ADDREF, 64'h8000_5000,   STAT_OK,         64'd0, 1'b0, 8'd1);
    plan_chk(CMD_FREE,   64'h8000_5000,   STAT_OK,         64'd0, 1'b1, 8'd0);
    // page 0 now managed since the kernel end lies below base; its push is lost
    plan_chk(CMD_ADDREF, 64'h8000_0000,   STAT_OK,         64'd0, 1'b0, 8'd1);
    plan_chk(CMD_FREE,   64'h8000_0000,   STAT_OK,         64'd0, 1'b1, 8'd0);
    plan_req(CMD_ALLOC,  64'h0, 2);
    // registers at all ones: one page, under the kernel end until that is cleared
    plan_reg(CFG_MEMORY_BASE, '1);
    plan_reg(CFG_KERNEL_END,  '1);
    plan_chk(CMD_ADDREF, 64'hFFFF_FFFF_FFFF_F000, STAT_BAD_ADDR, 64'd0, 1'b0, 8'd0);
    plan_reg(CFG_KERNEL_END,  64'h0);
    plan_chk(CMD_ADDREF, 64'hFFFF_FFFF_FFFF_F000, STAT_OK,       64'd0, 1'b0, 8'd1);
    plan_chk(CMD_FREE,   64'hFFFF_FFFF_FFFF_F000, STAT_OK,       64'd0, 1'b1, 8'd0);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        // directed part, no idling; the clearing pass holds off the first request
        foreach (directed_steps[k]) begin
          if (directed_steps[k].kind == ROW_REG) begin
            write_reg(directed_steps[k].sel, directed_steps[k].value);
          end else begin
            for (int unsigned n = 0; n < directed_steps[k].reps; n++) begin
              send_req(directed_steps[k].cmd, directed_steps[k].value,
                       directed_steps[k].typed && n == directed_steps[k].reps - 1,
                       directed_steps[k].want);
            end
          end
        end

        // random part: four phases of idling (none, request side, result side, both), each a few small pools
        for (int unsigned phase = 0; phase < 4; phase++) begin
          case (phase)
            0:       begin send_pct = 0;  recv_pct = 0;  end
            1:       begin send_pct = 63; recv_pct = 0;  end
            2:       begin send_pct = 0;  recv_pct = 63; end
            default: begin send_pct = 30; recv_pct = 30; end
          endcase
          for (int unsigned sc = 0; sc < SCENARIOS; sc++) begin
            // base: default, random, zero or near the top; low bits are ignored
            case ($urandom_range(3))
              0: base_reg = 64'h8000_0000 | 64'($urandom_range(4095));
              1: begin
                base_reg = {$urandom, $urandom};
                // keep the whole pool below the top of the address space
                if (base_reg[63:27] == '1) base_reg[27] = 1'b0;
              end
              2:       base_reg = 64'($urandom_range(4095));
              default: base_reg = 64'hFFFF_FFFF_F800_0000 | 64'($urandom_range(4095));
            endcase
            b_al = {base_reg[63:12], 12'd0};
            // small pools so the list runs dry often; now and then an empty one
            pool  = ($urandom_range(99) < 5) ? 0 : $urandom_range(24, 1);
            first = PAGE_COUNT - pool;
            if (pool == 0) begin
              kend_reg = '1;
            end else begin
              kend_reg = b_al + (64'(first) << 12) - 64'($urandom_range(4095));
            end
            write_reg(CFG_MEMORY_BASE, base_reg);
            write_reg(CFG_KERNEL_END, kend_reg);
            send_req(CMD_INIT, {$urandom, $urandom}, 1'b0, '0);

            for (int unsigned it = 0; it < SCEN_ITEMS; it++) begin
              r   = $urandom_range(99);
              idx = first + ((pool == 0) ? 0 : $urandom_range(pool - 1));
              pa  = b_al + (64'(idx) << 12);
              if (r < 2) begin
                cmd = CMD_INIT;
                pa  = {$urandom, $urandom};
              end else if (r < 37) begin
                cmd = CMD_ALLOC;
                pa  = {$urandom, $urandom};
              end else if (r < 62) begin
                cmd = CMD_FREE;
              end else if (r < 80) begin
                cmd = CMD_ADDREF;
              end else begin
                // broken addresses
                cmd = $urandom_range(1) ? CMD_FREE : CMD_ADDREF;
                case ($urandom_range(4))
                  0: pa = pa | 64'($urandom_range(4095, 1));
                  1: pa = b_al - (64'($urandom_range(8, 1)) << 12);
                  2: pa = b_al + (64'(PAGE_COUNT + $urandom_range(7)) << 12);
                  3: pa = b_al + (64'($urandom_range(first - 1)) << 12);
                  default: pa = {$urandom, $urandom};
                endcase
              end
              send_req(cmd, pa, 1'b0, '0);
            end
          end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
        repeat (10) @(posedge clk_i);
      end
      begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
      end
    join_any

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Simulation FAILED");
    end else begin
      $display("%0d requests over four idling phases, %0d results checked, %0d mismatches",
               requests_sent, results_checked, mismatches);
      $display("statuses seen: ok %0d, bad address %0d, zero count %0d, out of pages %0d, %s %0d",
               status_tally[STAT_OK], status_tally[STAT_BAD_ADDR],
               status_tally[STAT_ZERO_COUNT], status_tally[STAT_NO_PAGES],
               "saturated", status_tally[STAT_SATURATED]);
      if (mismatches == 0 && pending_results.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end
    $finish;
  end

endmodule
